// ===== src/double_ended_queue_core_defines.svh =====
// ----------------------------------------------------------------------------
// Double-ended queue core: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// check a property at every clock edge outside reset
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition in one cycle implies another in the next
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation and status codes, controller states, control structs.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH         = 16;
  localparam int PTR_W         = $clog2(DEPTH);
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int OP_W          = 3;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;
  localparam int S_TDATA_W     = 32;
  localparam int S_TUSER_W     = 3;
  localparam int M_TDATA_W     = 40;
  localparam int M_TUSER_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic capture_pop;
    logic load_out;
  } dq_cmd_t;

  typedef struct packed {
    logic pop_read;
    logic out_free;
  } dq_stat_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    if (p == '0) begin
      return PTR_W'(DEPTH - 1);
    end
    return p - PTR_W'(1);
  endfunction

  function automatic logic [ENTRY_COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+ENTRY_COUNT_W-1:0] wide;
    wide = {{ENTRY_COUNT_W{1'b0}}, c};
    return wide[ENTRY_COUNT_W-1:0];
  endfunction

endpackage

// ===== src/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request through execute, optional read and result hand-off.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t  cmd_o
);

  dq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      dq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = dq_pkg::S_EXEC;
        end
      end
      dq_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.pop_read ? dq_pkg::S_READ : dq_pkg::S_EMIT;
      end
      dq_pkg::S_READ: begin
        cmd_o.capture_pop = 1'b1;
        state_d           = dq_pkg::S_EMIT;
      end
      dq_pkg::S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = dq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Entry store, front and back positions, count, result and output registers.
// ----------------------------------------------------------------------------
module dq_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dq_pkg::dq_cmd_t                cmd_i,
  output dq_pkg::dq_stat_t               stat_o,
  input  logic [dq_pkg::OP_W-1:0]        op_i,
  input  logic [dq_pkg::VALUE_W-1:0]     value_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [dq_pkg::STATUS_W-1:0]    out_status_o,
  output logic [dq_pkg::VALUE_W-1:0]     out_popped_o,
  output logic [dq_pkg::ENTRY_COUNT_W-1:0] out_count_o
);

  logic [dq_pkg::OP_W-1:0]    op_q;
  logic [dq_pkg::VALUE_W-1:0] val_q;
  logic [dq_pkg::PTR_W-1:0]   front_q, front_d;
  logic [dq_pkg::PTR_W-1:0]   back_q, back_d;
  logic [dq_pkg::CNT_W-1:0]   count_q, count_d;
  dq_pkg::status_e            status_d;
  logic                       pop_read;
  logic                       wr_en;
  logic [dq_pkg::PTR_W-1:0]   wr_addr;
  logic                       rd_en;
  logic [dq_pkg::PTR_W-1:0]   rd_addr;
  logic [dq_pkg::VALUE_W-1:0] rd_data;
  logic                       full;
  logic                       empty;

  logic [dq_pkg::STATUS_W-1:0]      res_status_q;
  logic [dq_pkg::VALUE_W-1:0]       res_pop_q;
  logic [dq_pkg::CNT_W-1:0]         res_count_q;
  logic                             out_valid_q, out_valid_d;
  logic [dq_pkg::STATUS_W-1:0]      out_status_q;
  logic [dq_pkg::VALUE_W-1:0]       out_popped_q;
  logic [dq_pkg::ENTRY_COUNT_W-1:0] out_count_q;

  assign full  = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    front_d  = front_q;
    back_d   = back_q;
    count_d  = count_q;
    status_d = dq_pkg::STATUS_OK;
    pop_read = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = back_q;
    rd_addr  = front_q;
    case (dq_pkg::op_e'(op_q))
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_d = dq_pkg::STATUS_FULL;
        end else begin
          front_d = dq_pkg::ptr_dec(front_q);
          wr_en   = 1'b1;
          wr_addr = dq_pkg::ptr_dec(front_q);
          count_d = count_q + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_d = dq_pkg::STATUS_FULL;
        end else begin
          wr_en   = 1'b1;
          wr_addr = back_q;
          back_d  = dq_pkg::ptr_inc(back_q);
          count_d = count_q + dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status_d = dq_pkg::STATUS_EMPTY;
        end else begin
          pop_read = 1'b1;
          rd_addr  = front_q;
          front_d  = dq_pkg::ptr_inc(front_q);
          count_d  = count_q - dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_d = dq_pkg::STATUS_EMPTY;
        end else begin
          pop_read = 1'b1;
          rd_addr  = dq_pkg::ptr_dec(back_q);
          back_d   = dq_pkg::ptr_dec(back_q);
          count_d  = count_q - dq_pkg::CNT_W'(1);
        end
      end
      dq_pkg::OP_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign rd_en = cmd_i.exec & pop_read;

  dq_ram #(
    .Width (dq_pkg::VALUE_W),
    .Depth (dq_pkg::DEPTH)
  ) u_entry_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.exec & wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (val_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      back_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= op_i;
      val_q <= value_i;
    end
    if (cmd_i.exec) begin
      res_status_q <= status_d;
      res_count_q  <= count_d;
      res_pop_q    <= '0;
    end
    if (cmd_i.capture_pop) begin
      res_pop_q <= rd_data;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_popped_q <= res_pop_q;
      out_count_q  <= dq_pkg::count_field(res_count_q);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign stat_o.pop_read = pop_read;
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_popped_o = out_popped_q;
  assign out_count_o  = out_count_q;

endmodule

// ===== src/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit values: push and pop at either end, clear.
//
//   Channel  Dir  tdata (low bit up)                          tuser
//   s_axis   in   push_value[31:0]                            operation[2:0]
//   m_axis   out  popped_value[31:0], entry_count[36:32], 0   status[1:0]
//
// A request without a store read (push, clear, refused pop, unused code)
// steps through accept, execute and load output. A pop that reads the store
// adds a read step for the registered read, between execute and load output.
// One request is in flight at a time; the next is taken once the result
// sits in the output register, even while m_axis stalls it. Hold in emit while
// that register is full and m_axis_tready is low.
// Reset is asynchronous; positions and count clear at once, the store does not.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [dq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // push_value
  input  logic [dq_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // operation
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [dq_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // popped_value, entry_count, pad
  output logic [dq_pkg::M_TUSER_W-1:0]   m_axis_tuser   // status
);

  dq_pkg::dq_cmd_t                  cmd;
  dq_pkg::dq_stat_t                 stat;
  logic [dq_pkg::STATUS_W-1:0]      out_status;
  logic [dq_pkg::VALUE_W-1:0]       out_popped;
  logic [dq_pkg::ENTRY_COUNT_W-1:0] out_count;
  logic                             count_in_range;
  logic                             full_at_depth;
  logic                             empty_clean;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (s_axis_tuser),
    .value_i      (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_popped_o (out_popped),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata = {{(dq_pkg::M_TDATA_W - dq_pkg::VALUE_W - dq_pkg::ENTRY_COUNT_W){1'b0}},
                         out_count, out_popped};
  assign m_axis_tuser = out_status;

  assign count_in_range = (out_count <= dq_pkg::ENTRY_COUNT_W'(dq_pkg::DEPTH));
  assign full_at_depth  = (out_status != dq_pkg::STATUS_FULL) ||
                          (out_count == dq_pkg::ENTRY_COUNT_W'(dq_pkg::DEPTH));
  assign empty_clean    = (out_status != dq_pkg::STATUS_EMPTY) ||
                          ((out_popped == '0) && (out_count == '0));

  `DQ_ASSERT(a_count_bounded, !m_axis_tvalid || count_in_range, "entry count above depth")
  `DQ_ASSERT(a_full_count, !m_axis_tvalid || full_at_depth, "full status with queue not full")
  `DQ_ASSERT(a_empty_pop_zero, !m_axis_tvalid || empty_clean, "empty status with data or count")
  `DQ_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while another in flight")

endmodule

// ===== tb/sv/double_ended_queue_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core: checker
// Watches both stream channels. Each accepted request is run through a
// behavioral deque of its own, and the predicted response is queued. Each
// accepted response is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module double_ended_queue_core_checker
  import dq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // push_value
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // operation
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,   // popped_value, entry_count, pad
  input  logic [M_TUSER_W-1:0] m_axis_tuser,   // status
  output int                   err_count_o,
  output int                   pending_o
);

  typedef struct {
    status_e                  status;
    logic [VALUE_W-1:0]       popped;
    logic [ENTRY_COUNT_W-1:0] count;
  } deque_result_t;

  logic [VALUE_W-1:0] entry_store [DEPTH];
  logic [PTR_W-1:0]   front_pos;
  logic [PTR_W-1:0]   back_pos;
  logic [CNT_W-1:0]   held_count;
  deque_result_t      pending_results [$];
  int                 mismatch_count;

  function automatic deque_result_t predict_deque(input logic [OP_W-1:0] op,
                                                  input logic [VALUE_W-1:0] value);
    deque_result_t res;
    res.status = STATUS_OK;
    res.popped = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (held_count == CNT_W'(DEPTH)) begin
          res.status = STATUS_FULL;
        end else begin
          front_pos = front_pos - PTR_W'(1);
          entry_store[front_pos] = value;
          held_count = held_count + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (held_count == CNT_W'(DEPTH)) begin
          res.status = STATUS_FULL;
        end else begin
          entry_store[back_pos] = value;
          back_pos = back_pos + PTR_W'(1);
          held_count = held_count + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (held_count == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.popped = entry_store[front_pos];
          front_pos = front_pos + PTR_W'(1);
          held_count = held_count - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (held_count == '0) begin
          res.status = STATUS_EMPTY;
        end else begin
          back_pos = back_pos - PTR_W'(1);
          res.popped = entry_store[back_pos];
          held_count = held_count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        front_pos = '0;
        back_pos = '0;
        held_count = '0;
      end
      default: begin
      end
    endcase
    res.count = held_count[ENTRY_COUNT_W-1:0];
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [VALUE_W-1:0] want,
                                      input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      front_pos = '0;
      back_pos = '0;
      held_count = '0;
      pending_results.delete();
      mismatch_count = 0;
      err_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: response with no request pending, expected none actual %0h/%0h",
                   $time, m_axis_tuser, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", VALUE_W'(want.status), VALUE_W'(m_axis_tuser));
          check_field("popped_value", want.popped, m_axis_tdata[VALUE_W-1:0]);
          check_field("entry_count", VALUE_W'(want.count),
                      VALUE_W'(m_axis_tdata[VALUE_W +: ENTRY_COUNT_W]));
          check_field("pad", '0, VALUE_W'(m_axis_tdata[M_TDATA_W-1:VALUE_W+ENTRY_COUNT_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(predict_deque(s_axis_tuser, s_axis_tdata));
      end
      err_count_o <= mismatch_count;
      pending_o <= pending_results.size();
    end
  end

endmodule

// ===== tb/sv/double_ended_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue core: testbench top
// Drives a directed sequence (empty pops, fill to full, refused pushes,
// unused codes, clear) and then random requests in push-heavy, pop-heavy
// and balanced phases, with bursty requests and a stalling receiver.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;    // push_value
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;    // operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // popped_value, entry_count, pad
  logic [M_TUSER_W-1:0] m_axis_tuser;         // status

  int err_count;
  int pending;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_hold = 0;

  double_ended_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  double_ended_queue_core_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hold a request until accepted, then either continue the burst or pause
  task automatic issue(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 24);
      burst_left = $urandom_range(0, 60);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
          rx_hold <= $urandom_range(1, 10);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("double_ended_queue_core_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int push_pct;
    int phase_left;
    int pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, fill to full with wrap at the front, refused pushes
    issue(OP_POP_FRONT, $urandom);
    issue(OP_POP_BACK, $urandom);
    issue(OP_PUSH_FRONT, VALUE_MAX);
    issue(OP_PUSH_BACK, VALUE_MIN);
    for (int i = 0; i < DEPTH - 2; i++) begin
      issue((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
            (i == 0) ? '0 : (i == 1) ? '1 : (i == 2) ? 32'd1 : $urandom);
    end
    issue(OP_PUSH_FRONT, $urandom);
    issue(OP_PUSH_BACK, $urandom);
    issue(OP_POP_BACK, $urandom);
    issue(OP_POP_FRONT, $urandom);
    for (int i = 0; i < 3; i++) begin
      issue(OP_UNUSED_FIRST + OP_W'(i), $urandom);
    end
    issue(OP_CLEAR, $urandom);

    push_pct = 50;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 70;
          1: push_pct = 25;
          default: push_pct = 48;
        endcase
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        issue(OP_CLEAR, $urandom);
      end else if (pick < 4) begin
        issue(OP_UNUSED_FIRST + OP_W'($urandom_range(0, 2)), $urandom);
      end else if (pick < 4 + push_pct) begin
        issue($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
      end else begin
        issue($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("double_ended_queue_core_tb: clean");
    end else begin
      $display("double_ended_queue_core_tb: errors");
    end
    $finish;
  end

endmodule
